// ===== design/svu_pkg.sv =====
package svu_pkg;

    localparam int FRAC_BITS = 16;

    // field widths
    localparam int DATA_W = 32;
    localparam int REG_W  = 31;
    localparam int MODE_W = 3;
    localparam int IDX_W  = 3;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_SEEK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLEE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ARRIVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PURSUIT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EVADE   = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED = 3'd1;
    localparam logic [IDX_W-1:0] REG_FLEE_RAD  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOW_RAD  = 3'd3;
    localparam logic [IDX_W-1:0] REG_EVADE_RAD = 3'd4;

    localparam logic [REG_W-1:0] SLOW_RAD_RST = REG_W'(64'd1 << FRAC_BITS);

    // vector measurement
    localparam int MAG_W  = 31;
    localparam int MEAS_W = 37;
    localparam int SH_W   = 3;

    // pipelined units
    localparam int SQ_STEPS  = 32;
    localparam int DV_STEPS  = 32;
    localparam int BACK_LAT  = 12 + 2 * SQ_STEPS + 2 * DV_STEPS;

    // front to back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             nx;
        logic             ny;
        logic [SH_W-1:0]  sh;
    } t_meas;

    typedef struct packed {
        t_meas       dm;
        t_meas       vm;
        logic [31:0] tx;
        logic [31:0] ty;
        logic [32:0] tvx;
        logic [32:0] tvy;
        logic [31:0] ax;
        logic [31:0] ay;
    } t_front;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  max_speed;
        logic [REG_W-1:0]  flee_radius;
        logic [REG_W-1:0]  slow_radius;
        logic [REG_W-1:0]  evade_radius;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] steer_x;
        logic signed [DATA_W-1:0] steer_y;
        logic                     applied;
    } t_res;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] lo;
    } t_dv;

    // magnitudes, signs and the right shift that brings both below 2^31
    function automatic t_meas measure(input logic [MEAS_W-1:0] dx,
                                      input logic [MEAS_W-1:0] dy);
        logic [MEAS_W-1:0] amx;
        logic [MEAS_W-1:0] amy;
        logic [MEAS_W-1:0] mor;
        logic [MEAS_W-1:0] shx;
        logic [MEAS_W-1:0] shy;
        logic [SH_W-1:0]   sh;
        t_meas             m;
        amx = dx[MEAS_W-1] ? (~dx + MEAS_W'(1)) : dx;
        amy = dy[MEAS_W-1] ? (~dy + MEAS_W'(1)) : dy;
        mor = amx | amy;
        sh  = '0;
        for (int i = MAG_W; i < MEAS_W; i++) begin
            if (mor[i]) begin
                sh = SH_W'(i - (MAG_W - 1));
            end
        end
        shx  = amx >> sh;
        shy  = amy >> sh;
        m.mx = shx[MAG_W-1:0];
        m.my = shy[MAG_W-1:0];
        m.nx = dx[MEAS_W-1];
        m.ny = dy[MEAS_W-1];
        m.sh = sh;
        return m;
    endfunction

    // one digit of the integer square root
    function automatic t_sq sq_step(input t_sq s);
        logic [35:0] t_rem;
        logic [35:0] trial;
        t_sq         n;
        t_rem = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        n.rad = {s.rad[61:0], 2'b00};
        if (t_rem >= trial) begin
            n.rem  = 34'(t_rem - trial);
            n.root = {s.root[30:0], 1'b1};
        end else begin
            n.rem  = t_rem[33:0];
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_sq sq_init(input logic [63:0] rad);
        t_sq s;
        s.rad  = rad;
        s.rem  = '0;
        s.root = '0;
        return s;
    endfunction

    // one quotient bit of a restoring divide, quotient collects in lo
    function automatic t_dv dv_step(input t_dv s, input logic [31:0] den);
        logic [32:0] t_rem;
        t_dv         n;
        t_rem = {s.rem, s.lo[31]};
        if (t_rem >= {1'b0, den}) begin
            n.rem = 32'(t_rem - {1'b0, den});
            n.lo  = {s.lo[30:0], 1'b1};
        end else begin
            n.rem = t_rem[31:0];
            n.lo  = {s.lo[30:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_dv dv_init(input logic [63:0] num);
        t_dv s;
        s.rem = num[63:32];
        s.lo  = num[31:0];
        return s;
    endfunction

endpackage

// ===== design/svu_front.sv =====
module svu_front import svu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [DATA_W-1:0] i_agent_x,
    input  logic signed [DATA_W-1:0] i_agent_y,
    input  logic signed [DATA_W-1:0] i_target_x,
    input  logic signed [DATA_W-1:0] i_target_y,
    input  logic signed [DATA_W-1:0] i_target_vel_x,
    input  logic signed [DATA_W-1:0] i_target_vel_y,
    input  logic                     i_q_full,
    output logic                     o_vld,
    output t_front                   o_dat
);

    logic              r_vld;
    logic              n_vld;
    t_front            r_dat;
    t_front            n_dat;
    logic              accept;
    logic [MEAS_W-1:0] dx;
    logic [MEAS_W-1:0] dy;
    logic [MEAS_W-1:0] vx;
    logic [MEAS_W-1:0] vy;

    assign o_full = r_vld & i_q_full;
    assign accept = i_push & ~o_full;
    assign n_vld  = accept | (r_vld & i_q_full);
    assign o_vld  = r_vld;
    assign o_dat  = r_dat;

    always_comb begin
        dx = {{5{i_target_x[31]}}, i_target_x} - {{5{i_agent_x[31]}}, i_agent_x};
        dy = {{5{i_target_y[31]}}, i_target_y} - {{5{i_agent_y[31]}}, i_agent_y};
        vx = {{5{i_target_vel_x[31]}}, i_target_vel_x};
        vy = {{5{i_target_vel_y[31]}}, i_target_vel_y};
        n_dat.dm  = measure(dx, dy);
        n_dat.vm  = measure(vx, vy);
        n_dat.tx  = i_target_x;
        n_dat.ty  = i_target_y;
        n_dat.tvx = {i_target_x[31], i_target_x} + {i_target_vel_x[31], i_target_vel_x};
        n_dat.tvy = {i_target_y[31], i_target_y} + {i_target_vel_y[31], i_target_vel_y};
        n_dat.ax  = i_agent_x;
        n_dat.ay  = i_agent_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dat <= n_dat;
        end
    end

endmodule

// ===== design/svu_fifo.sv =====
module svu_fifo import svu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_front i_dat,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_front o_dat
);

    t_front             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_dat   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_dat;
        end
    end

endmodule

// ===== design/svu_back.sv =====
module svu_back import svu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_q_vld,
    input  t_front i_q_dat,
    output logic   o_q_pop,
    input  t_cfg   i_cfg,
    output logic   o_res_vld,
    output t_res   o_res
);

    typedef struct packed {
        t_meas       dm;
        logic [31:0] ls_d;
        t_meas       vm;
        logic [31:0] ls_v;
        logic [31:0] tx;
        logic [31:0] ty;
        logic [32:0] tvx;
        logic [32:0] tvy;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [33:0] dlen;
        logic [32:0] vl;
        logic [33:0] dif;
        logic [31:0] adif;
        logic        use_off;
        logic        far_flee;
        logic        far_evade;
        logic        slow;
    } t_mid;

    typedef struct packed {
        t_meas            dm;
        logic [31:0]      ls_d;
        logic             far_flee;
        logic             far_evade;
        logic [REG_W-1:0] speed;
        logic [31:0]      ax;
        logic [31:0]      ay;
        logic [MEAS_W-1:0] aimx;
        logic [MEAS_W-1:0] aimy;
        logic [MEAS_W-1:0] delx;
        logic [MEAS_W-1:0] dely;
        t_meas            am;
    } t_aim;

    typedef struct packed {
        logic        nx;
        logic        ny;
        logic        negall;
        logic        zero_out;
        logic        applied;
        logic [31:0] ls;
    } t_fin;

    logic [BACK_LAT-1:0] r_vld;

    // squares and first root
    t_front      r_b0_fd;
    logic [61:0] r_b0_sq [4];
    t_front      r_s1_fd [0:SQ_STEPS];
    t_sq         r_s1_d  [0:SQ_STEPS];
    t_sq         r_s1_v  [0:SQ_STEPS];

    // lengths, offset and arrive divides
    t_mid        r_b2;
    t_mid        n_b2;
    t_mid        r_b3;
    t_mid        n_b3;
    t_mid        n_b4;
    t_dv         n_b4_x;
    t_dv         n_b4_y;
    t_dv         n_b4_a;
    t_mid        r_v1_m  [0:DV_STEPS];
    t_dv         r_v1_x  [0:DV_STEPS];
    t_dv         r_v1_y  [0:DV_STEPS];
    t_dv         r_v1_a  [0:DV_STEPS];

    // aim point and second root
    t_aim        r_b5;
    t_aim        n_b5;
    t_aim        r_b6;
    t_aim        n_b6;
    t_aim        r_b7;
    t_aim        n_b7;
    t_aim        r_b8;
    logic [61:0] r_b8_sq [2];
    t_aim        r_s2_m  [0:SQ_STEPS];
    t_sq         r_s2_a  [0:SQ_STEPS];

    // final scaling
    t_fin        n_b10;
    t_dv         n_b10_x;
    t_dv         n_b10_y;
    t_fin        r_v2_f  [0:DV_STEPS];
    t_dv         r_v2_x  [0:DV_STEPS];
    t_dv         r_v2_y  [0:DV_STEPS];
    t_res        r_res;
    t_res        n_res;

    assign o_q_pop   = i_en & i_q_vld;
    assign o_res_vld = r_vld[BACK_LAT-1];
    assign o_res     = r_res;

    // lengths and range flags
    always_comb begin
        n_b2         = '0;
        n_b2.dm      = r_s1_fd[SQ_STEPS].dm;
        n_b2.vm      = r_s1_fd[SQ_STEPS].vm;
        n_b2.ls_d    = r_s1_d[SQ_STEPS].root;
        n_b2.ls_v    = r_s1_v[SQ_STEPS].root;
        n_b2.tx      = r_s1_fd[SQ_STEPS].tx;
        n_b2.ty      = r_s1_fd[SQ_STEPS].ty;
        n_b2.tvx     = r_s1_fd[SQ_STEPS].tvx;
        n_b2.tvy     = r_s1_fd[SQ_STEPS].tvy;
        n_b2.ax      = r_s1_fd[SQ_STEPS].ax;
        n_b2.ay      = r_s1_fd[SQ_STEPS].ay;
        n_b2.dlen    = 34'(n_b2.ls_d) << n_b2.dm.sh;
        n_b2.vl      = 33'(n_b2.ls_v) << n_b2.vm.sh;
        n_b2.dif     = {3'b000, i_cfg.max_speed} - {1'b0, n_b2.vl};
        n_b2.far_flee  = n_b2.dlen > {3'b000, i_cfg.flee_radius};
        n_b2.far_evade = n_b2.dlen > {3'b000, i_cfg.evade_radius};
        n_b2.slow      = n_b2.dlen < {3'b000, i_cfg.slow_radius};
    end

    always_comb begin
        n_b3      = r_b2;
        n_b3.adif = r_b2.dif[33] ? 32'(~r_b2.dif + 34'd1) : r_b2.dif[31:0];
    end

    // offset and arrive numerators
    always_comb begin
        logic [62:0] px;
        logic [62:0] py;
        logic [61:0] pa;
        n_b4         = r_b3;
        n_b4.use_off = {1'b0, r_b3.adif} <= r_b3.vl;
        px           = r_b3.vm.mx * r_b3.adif;
        py           = r_b3.vm.my * r_b3.adif;
        pa           = i_cfg.max_speed * r_b3.dlen[30:0];
        n_b4_x       = dv_init(64'(px));
        n_b4_y       = dv_init(64'(py));
        n_b4_a       = dv_init(64'(pa));
    end

    // aim point and arrive speed
    always_comb begin
        t_mid              m;
        logic [31:0]       offx;
        logic [31:0]       offy;
        logic [MEAS_W-1:0] tvx;
        logic [MEAS_W-1:0] tvy;
        logic              negx;
        logic              negy;
        m     = r_v1_m[DV_STEPS];
        offx  = (m.ls_v == '0) ? '0 : r_v1_x[DV_STEPS].lo;
        offy  = (m.ls_v == '0) ? '0 : r_v1_y[DV_STEPS].lo;
        tvx   = {{4{m.tvx[32]}}, m.tvx};
        tvy   = {{4{m.tvy[32]}}, m.tvy};
        negx  = m.vm.nx ^ m.dif[33];
        negy  = m.vm.ny ^ m.dif[33];
        n_b5           = '0;
        n_b5.dm        = m.dm;
        n_b5.ls_d      = m.ls_d;
        n_b5.far_flee  = m.far_flee;
        n_b5.far_evade = m.far_evade;
        n_b5.ax        = m.ax;
        n_b5.ay        = m.ay;
        if (!m.use_off) begin
            n_b5.aimx = {{5{m.tx[31]}}, m.tx};
            n_b5.aimy = {{5{m.ty[31]}}, m.ty};
        end else begin
            n_b5.aimx = negx ? (tvx + {5'b0, offx}) : (tvx - {5'b0, offx});
            n_b5.aimy = negy ? (tvy + {5'b0, offy}) : (tvy - {5'b0, offy});
        end
        if (i_cfg.mode == MODE_ARRIVE && m.slow) begin
            n_b5.speed = r_v1_a[DV_STEPS].lo[REG_W-1:0];
        end else begin
            n_b5.speed = i_cfg.max_speed;
        end
    end

    always_comb begin
        n_b6      = r_b5;
        n_b6.delx = r_b5.aimx - {{5{r_b5.ax[31]}}, r_b5.ax};
        n_b6.dely = r_b5.aimy - {{5{r_b5.ay[31]}}, r_b5.ay};
    end

    always_comb begin
        n_b7    = r_b6;
        n_b7.am = measure(r_b6.delx, r_b6.dely);
    end

    // pick the vector to scale and form its numerators
    always_comb begin
        t_aim             m;
        logic             pur;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [61:0]      px;
        logic [61:0]      py;
        m   = r_s2_m[SQ_STEPS];
        pur = (i_cfg.mode == MODE_PURSUIT) || (i_cfg.mode == MODE_EVADE);
        mx  = pur ? m.am.mx : m.dm.mx;
        my  = pur ? m.am.my : m.dm.my;
        n_b10.nx = pur ? m.am.nx : m.dm.nx;
        n_b10.ny = pur ? m.am.ny : m.dm.ny;
        n_b10.ls = pur ? r_s2_a[SQ_STEPS].root : m.ls_d;
        case (i_cfg.mode)
            MODE_SEEK:    n_b10.applied = 1'b1;
            MODE_FLEE:    n_b10.applied = ~m.far_flee;
            MODE_ARRIVE:  n_b10.applied = 1'b1;
            MODE_PURSUIT: n_b10.applied = 1'b1;
            MODE_EVADE:   n_b10.applied = ~m.far_evade;
            default:      n_b10.applied = 1'b0;
        endcase
        n_b10.negall   = (i_cfg.mode == MODE_FLEE) || (i_cfg.mode == MODE_EVADE);
        n_b10.zero_out = ~n_b10.applied || (n_b10.ls == '0);
        px      = mx * m.speed;
        py      = my * m.speed;
        n_b10_x = dv_init(64'(px));
        n_b10_y = dv_init(64'(py));
    end

    // signs and zeroing
    always_comb begin
        t_fin        f;
        logic [31:0] qx;
        logic [31:0] qy;
        f  = r_v2_f[DV_STEPS];
        qx = r_v2_x[DV_STEPS].lo;
        qy = r_v2_y[DV_STEPS].lo;
        n_res.applied = f.applied;
        if (f.zero_out) begin
            n_res.steer_x = '0;
            n_res.steer_y = '0;
        end else begin
            n_res.steer_x = (f.nx ^ f.negall) ? (~qx + 32'd1) : qx;
            n_res.steer_y = (f.ny ^ f.negall) ? (~qy + 32'd1) : qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_q_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b0_fd    <= i_q_dat;
            r_b0_sq[0] <= i_q_dat.dm.mx * i_q_dat.dm.mx;
            r_b0_sq[1] <= i_q_dat.dm.my * i_q_dat.dm.my;
            r_b0_sq[2] <= i_q_dat.vm.mx * i_q_dat.vm.mx;
            r_b0_sq[3] <= i_q_dat.vm.my * i_q_dat.vm.my;

            r_s1_fd[0] <= r_b0_fd;
            r_s1_d[0]  <= sq_init(64'(r_b0_sq[0]) + 64'(r_b0_sq[1]));
            r_s1_v[0]  <= sq_init(64'(r_b0_sq[2]) + 64'(r_b0_sq[3]));
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_s1_fd[k] <= r_s1_fd[k-1];
                r_s1_d[k]  <= sq_step(r_s1_d[k-1]);
                r_s1_v[k]  <= sq_step(r_s1_v[k-1]);
            end

            r_b2 <= n_b2;
            r_b3 <= n_b3;

            r_v1_m[0] <= n_b4;
            r_v1_x[0] <= n_b4_x;
            r_v1_y[0] <= n_b4_y;
            r_v1_a[0] <= n_b4_a;
            for (int k = 1; k <= DV_STEPS; k++) begin
                r_v1_m[k] <= r_v1_m[k-1];
                r_v1_x[k] <= dv_step(r_v1_x[k-1], r_v1_m[k-1].ls_v);
                r_v1_y[k] <= dv_step(r_v1_y[k-1], r_v1_m[k-1].ls_v);
                r_v1_a[k] <= dv_step(r_v1_a[k-1], {1'b0, i_cfg.slow_radius});
            end

            r_b5       <= n_b5;
            r_b6       <= n_b6;
            r_b7       <= n_b7;
            r_b8       <= r_b7;
            r_b8_sq[0] <= r_b7.am.mx * r_b7.am.mx;
            r_b8_sq[1] <= r_b7.am.my * r_b7.am.my;

            r_s2_m[0] <= r_b8;
            r_s2_a[0] <= sq_init(64'(r_b8_sq[0]) + 64'(r_b8_sq[1]));
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_s2_m[k] <= r_s2_m[k-1];
                r_s2_a[k] <= sq_step(r_s2_a[k-1]);
            end

            r_v2_f[0] <= n_b10;
            r_v2_x[0] <= n_b10_x;
            r_v2_y[0] <= n_b10_y;
            for (int k = 1; k <= DV_STEPS; k++) begin
                r_v2_f[k] <= r_v2_f[k-1];
                r_v2_x[k] <= dv_step(r_v2_x[k-1], r_v2_f[k-1].ls);
                r_v2_y[k] <= dv_step(r_v2_y[k-1], r_v2_f[k-1].ls);
            end

            r_res <= n_res;
        end
    end

endmodule

// ===== design/steering_velocity_unit.sv =====
// steering velocity unit: one word in and one word out per clock when neither side stalls
// registers from the accepting edge to the result on the ports: one front stage,
// one queue slot, 140 back stages (two 32-step root pipelines, two 32-step divide pipelines)
// and one output buffer slot
// synchronous active-low reset empties every queue and restores the register defaults
module steering_velocity_unit import svu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration writes
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [REG_W-1:0]         i_cfg_wdata,
    // input words
    input  logic                     push,
    output logic                     full,
    input  logic signed [DATA_W-1:0] i_agent_x,
    input  logic signed [DATA_W-1:0] i_agent_y,
    input  logic signed [DATA_W-1:0] i_target_x,
    input  logic signed [DATA_W-1:0] i_target_y,
    input  logic signed [DATA_W-1:0] i_target_vel_x,
    input  logic signed [DATA_W-1:0] i_target_vel_y,
    // result words
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] o_steer_x,
    output logic signed [DATA_W-1:0] o_steer_y,
    output logic                     o_applied
);

    // configuration registers
    t_cfg   r_cfg;

    // front to queue
    logic   f_vld;
    t_front f_dat;
    logic   q_full;
    logic   q_empty;
    t_front q_dat;
    logic   q_pop;

    // back to output buffer
    logic   en;
    logic   res_vld;
    t_res   res;

    // two-word output buffer, keeps the back pipeline apart from the reader
    t_res       r_ob [2];
    logic       r_ob_wr;
    logic       r_ob_rd;
    logic [1:0] r_ob_cnt;
    logic       ob_full;
    logic       ob_push;
    logic       ob_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_SEEK;
            r_cfg.max_speed    <= '0;
            r_cfg.flee_radius  <= '0;
            r_cfg.slow_radius  <= SLOW_RAD_RST;
            r_cfg.evade_radius <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:      r_cfg.mode         <= i_cfg_wdata[MODE_W-1:0];
                REG_MAX_SPEED: r_cfg.max_speed    <= i_cfg_wdata;
                REG_FLEE_RAD:  r_cfg.flee_radius  <= i_cfg_wdata;
                REG_SLOW_RAD:  r_cfg.slow_radius  <= i_cfg_wdata;
                REG_EVADE_RAD: r_cfg.evade_radius <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // deltas, magnitudes and shifts
    svu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_agent_x      (i_agent_x),
        .i_agent_y      (i_agent_y),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_target_vel_x (i_target_vel_x),
        .i_target_vel_y (i_target_vel_y),
        .i_q_full       (q_full),
        .o_vld          (f_vld),
        .o_dat          (f_dat)
    );

    // short queue so the front keeps taking words while the back stalls
    svu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_dat   (f_dat),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_dat   (q_dat)
    );

    // the whole back pipeline holds while the output buffer is full
    assign en = ~ob_full;

    svu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_q_vld   (~q_empty),
        .i_q_dat   (q_dat),
        .o_q_pop   (q_pop),
        .i_cfg     (r_cfg),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    assign ob_full = (r_ob_cnt == 2'd2);
    assign empty   = (r_ob_cnt == 2'd0);
    assign ob_push = res_vld & en;
    assign ob_pop  = pop & ~empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr  <= 1'b0;
            r_ob_rd  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (ob_push) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (ob_pop) begin
                r_ob_rd <= ~r_ob_rd;
            end
            if (ob_push && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (ob_pop && !ob_push) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_ob_wr] <= res;
        end
    end

    // oldest waiting word
    assign o_steer_x = r_ob[r_ob_rd].steer_x;
    assign o_steer_y = r_ob[r_ob_rd].steer_y;
    assign o_applied = r_ob[r_ob_rd].applied;

endmodule
